// ===== rtl/core/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bpt_pkg
// shared types and codes for the breakpoint table: command codes, entry
// kinds, field widths and the controller to datapath command bundle
// ----------------------------------------------------------------------------
package bpt_pkg;

    // fixed field widths of one request item
    localparam int CMD_W  = 3;
    localparam int ADDR_W = 16;
    localparam int KIND_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_IGNORE     = 3'd4;

    // entry kinds
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // run the item and load the result register
    } bpt_ctrl_t;

endpackage

// ===== rtl/core/bpt_channels.sv =====
// ----------------------------------------------------------------------------
// bpt channels
// valid/ready channels for breakpoint table requests and results
// ----------------------------------------------------------------------------

// request channel: one command item
interface bpt_req_if;
    import bpt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] brk_type;

    modport source (output valid, output cmd, output addr, output brk_type, input ready);
    modport sink   (input valid, input cmd, input addr, input brk_type, output ready);
endinterface

// result channel: one result item per request
interface bpt_rsp_if;
    logic valid;
    logic ready;
    logic hit;
    logic full_res;

    modport source (output valid, output hit, output full_res, input ready);
    modport sink   (input valid, input hit, input full_res, output ready);
endinterface

// ===== rtl/core/bpt_controller.sv =====
// ----------------------------------------------------------------------------
// bpt_controller
// sequences one item at a time: capture, execute, then hold the result
// until the sink takes it; the next item may be captured meanwhile
// ----------------------------------------------------------------------------
module bpt_controller
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bpt_pkg::bpt_ctrl_t ctrl
);
    import bpt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    // result register can take a new value when empty or being drained
    assign out_free = !rsp_valid_reg || rsp_ready;

    // commands to the datapath
    assign req_ready = (state_reg == S_IDLE);
    assign ctrl.load = req_valid && req_ready;
    assign ctrl.exec = (state_reg == S_EXEC) && out_free;
    assign rsp_valid = rsp_valid_reg;

    // next state and result valid
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== rtl/core/bpt_datapath.sv =====
// ----------------------------------------------------------------------------
// bpt_datapath
// item register, flop slot table with parallel compare, lowest empty slot
// select, one-shot skip register and the result register
// ----------------------------------------------------------------------------
module bpt_datapath
#(
    parameter int NUM_SLOTS = 32,
    parameter int ADDR_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bpt_pkg::bpt_ctrl_t          ctrl,
    input  logic [bpt_pkg::CMD_W-1:0]   req_cmd,
    input  logic [bpt_pkg::ADDR_W-1:0]  req_addr,
    input  logic [bpt_pkg::KIND_W-1:0]  req_brk_type,
    output logic                        hit,
    output logic                        full_res
);
    import bpt_pkg::*;

    // captured item
    logic [CMD_W-1:0]     cmd_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [KIND_W-1:0]    kind_reg;

    // slot table
    logic [ADDR_BITS-1:0] slot_addr_reg [NUM_SLOTS];
    logic [KIND_W-1:0]    slot_kind_reg [NUM_SLOTS];
    logic [KIND_W-1:0]    slot_kind_next [NUM_SLOTS];

    // one-shot skip
    logic [ADDR_BITS-1:0] skip_addr_reg;
    logic [ADDR_BITS-1:0] skip_addr_next;
    logic                 skip_armed_reg;
    logic                 skip_armed_next;

    // result
    logic hit_reg;
    logic hit_next;
    logic full_reg;
    logic full_next;

    // compare vectors
    logic [NUM_SLOTS-1:0] empty_vec;
    logic [NUM_SLOTS-1:0] addr_match;
    logic [NUM_SLOTS-1:0] kind_match;
    logic [NUM_SLOTS-1:0] first_empty;
    logic                 set_en;
    logic                 skip_match;

    // capture the accepted item, address taken in its low bits
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= req_cmd;
            addr_reg <= ADDR_BITS'(req_addr);
            kind_reg <= req_brk_type;
        end
    end

    // parallel compare over all slots
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            empty_vec[i]  = (slot_kind_reg[i] == KIND_EMPTY);
            addr_match[i] = !empty_vec[i] && (slot_addr_reg[i] == addr_reg);
            kind_match[i] = addr_match[i] && (slot_kind_reg[i] == kind_reg);
        end
    end

    // lowest empty slot as a one-hot vector
    assign first_empty = empty_vec & ~(empty_vec - NUM_SLOTS'(1));
    assign set_en      = (cmd_reg == CMD_SET) && (kind_reg != KIND_EMPTY);
    assign skip_match  = skip_armed_reg && (skip_addr_reg == addr_reg);

    // command execution
    always_comb
    begin
        slot_kind_next  = slot_kind_reg;
        skip_addr_next  = skip_addr_reg;
        skip_armed_next = skip_armed_reg;
        hit_next        = 1'b0;
        full_next       = 1'b0;
        case (cmd_reg)
            CMD_SET:
            begin
                if (set_en)
                begin
                    full_next = !(|empty_vec);
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (first_empty[i])
                        begin
                            slot_kind_next[i] = kind_reg;
                        end
                    end
                end
            end
            CMD_REMOVE:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (addr_match[i])
                    begin
                        slot_kind_next[i] = KIND_EMPTY;
                    end
                end
            end
            CMD_REMOVE_ALL:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    slot_kind_next[i] = KIND_EMPTY;
                end
            end
            CMD_CHECK:
            begin
                // armed skip address swallows one check
                if (skip_match)
                begin
                    skip_armed_next = 1'b0;
                end
                else if (kind_reg != KIND_EMPTY)
                begin
                    hit_next = |kind_match;
                end
            end
            CMD_IGNORE:
            begin
                skip_addr_next  = addr_reg;
                skip_armed_next = 1'b1;
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    // slot kinds and skip state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_kind_reg[i] <= KIND_EMPTY;
            end
            skip_addr_reg  <= '0;
            skip_armed_reg <= 1'b0;
        end
        else if (ctrl.exec)
        begin
            slot_kind_reg  <= slot_kind_next;
            skip_addr_reg  <= skip_addr_next;
            skip_armed_reg <= skip_armed_next;
        end
    end

    // slot addresses, written only on set into the chosen slot
    always_ff @(posedge clk)
    begin
        if (ctrl.exec && set_en)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (first_empty[i])
                begin
                    slot_addr_reg[i] <= addr_reg;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            hit_reg  <= hit_next;
            full_reg <= full_next;
        end
    end

    assign hit      = hit_reg;
    assign full_res = full_reg;

endmodule

// ===== rtl/core/breakpoint_table_unit.sv =====
// ----------------------------------------------------------------------------
// breakpoint_table_unit
// typed breakpoint table: set, remove, remove-all, check and one-shot ignore
// ----------------------------------------------------------------------------
// sequence: each accepted request is captured, then executed over the whole slot
//   table and its result registered; no new request is taken until the current one
//   has executed, and execute waits while an earlier result is unread
// reset: asynchronous, all slots empty and the skip disarmed at once
module breakpoint_table_unit
#(
    parameter int NUM_SLOTS = 32,
    parameter int ADDR_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    bpt_req_if.sink    req,
    bpt_rsp_if.source  rsp
);
    import bpt_pkg::*;

    bpt_ctrl_t ctrl;

    // control sequencer
    bpt_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    // slot table and result
    bpt_datapath
    #(
        .NUM_SLOTS (NUM_SLOTS),
        .ADDR_BITS (ADDR_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .req_cmd      (req.cmd),
        .req_addr     (req.addr),
        .req_brk_type (req.brk_type),
        .hit          (rsp.hit),
        .full_res     (rsp.full_res)
    );

endmodule

// ===== rtl/core/bpt_checker.sv =====
// ----------------------------------------------------------------------------
// bpt_checker
// port-level checks on the breakpoint table, bound to the top level
// ----------------------------------------------------------------------------
module bpt_checker
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic hit,
    input logic full_res
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its fields
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(hit) && $stable(full_res))
        else $error("result changed while stalled");

    // one item at a time: no capture in the cycle after a capture
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in execution");

    // hit only comes from check and full only from set
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(hit && full_res))
        else $error("hit and full flagged together");

endmodule

bind breakpoint_table_unit bpt_checker u_bpt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .hit       (rsp.hit),
    .full_res  (rsp.full_res)
);
